[rtl/swqt_pkg.sv]
// ----------------------------------------------------------------------------
// swqt_pkg
// Shared types and constants for the sliding-window quality trimmer.
// ----------------------------------------------------------------------------
package swqt_pkg;

  localparam int MAX_WINDOW      = 64;
  localparam int MAX_READ_LENGTH = 65535;

  localparam int CHAR_W   = 8;
  localparam int QUAL_W   = 7;
  localparam int WIDTH_W  = 7;
  localparam int THR_W    = 11;
  localparam int SUM_W    = 13;
  localparam int POS_W    = 16;
  localparam int LINE_AW  = $clog2(MAX_WINDOW);
  localparam int LIMIT_W  = THR_W + WIDTH_W;
  localparam int CFG_DATA_W = 11;

  localparam logic [CHAR_W-1:0]  PHRED_OFFSET = 8'd33;
  localparam logic [QUAL_W-1:0]  QUAL_MAX     = 7'd127;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 7'd4;
  localparam logic [THR_W-1:0]   THR_RESET    = 11'd320;
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT  = WIDTH_W'(MAX_WINDOW);
  localparam logic [POS_W-1:0]   POS_LIMIT    = POS_W'(MAX_READ_LENGTH);

  typedef enum logic {
    CFG_WINDOW_WIDTH      = 1'b0,
    CFG_QUALITY_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CHAR_W-1:0] quality_char;
    logic              last_of_read;
  } in_item_t;

  typedef struct packed {
    logic             keep_read;
    logic [POS_W-1:0] keep_length;
  } out_item_t;

  // Control from the trimming core to the window delay line.
  typedef struct packed {
    logic               wr_en;
    logic [LINE_AW-1:0] wr_addr;
    logic [QUAL_W-1:0]  wr_data;
    logic [LINE_AW-1:0] rd_addr;
  } line_ctl_t;

endpackage

[rtl/swqt_window_line.sv]
// ----------------------------------------------------------------------------
// swqt_window_line
// Window delay line memory with a registered, prefetched read port.
// ----------------------------------------------------------------------------
module swqt_window_line
  import swqt_pkg::*;
(
  input  logic              clk,
  input  line_ctl_t         ctl,
  output logic [QUAL_W-1:0] rd_data
);

  logic [QUAL_W-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  // The read address is the pointer the next item will use, so the oldest
  // window entry is already registered when that item arrives. A write to that
  // same entry is forwarded.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_addr == ctl.rd_addr)) begin
      rd_data <= ctl.wr_data;
    end else begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

[rtl/swqt_out_buf.sv]
// ----------------------------------------------------------------------------
// swqt_out_buf
// Output register with a skid stage for result words.
// ----------------------------------------------------------------------------
module swqt_out_buf
  import swqt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      can_accept,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      skid_valid;
  out_item_t skid_data;
  logic      load_out;

  assign can_accept = !skid_valid;
  assign load_out   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[rtl/swqt_core.sv]
// ----------------------------------------------------------------------------
// swqt_core
// Per-read trimming state: window sum, position, cut and trailing-base tracking.
// ----------------------------------------------------------------------------
module swqt_core
  import swqt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_fire,
  input  in_item_t              in_item,
  input  logic [QUAL_W-1:0]     line_rd_data,
  output line_ctl_t             line_ctl,
  output logic                  res_valid,
  output out_item_t             res_data
);

  logic [WIDTH_W-1:0] cfg_width;
  logic [THR_W-1:0]   cfg_thr;

  logic [WIDTH_W-1:0] eff_width, eff_width_next;
  logic [THR_W-1:0]   eff_thr, eff_thr_next;
  logic [SUM_W-1:0]   window_sum, window_sum_next;
  logic [POS_W-1:0]   base_position, base_position_next;
  logic               cut_found, cut_found_next;
  logic [POS_W-1:0]   last_good_end, last_good_end_next;
  logic               read_failed, read_failed_next;
  logic [LINE_AW-1:0] line_ptr, line_ptr_next;

  logic [QUAL_W-1:0]  q;
  logic [CHAR_W-1:0]  q_raw;
  logic [WIDTH_W-1:0] width_sat, cur_w;
  logic [THR_W-1:0]   cur_thr;
  logic [LIMIT_W-1:0] limit;
  logic               first, active, filling, sliding, fails, good;
  logic [POS_W-1:0]   pos_inc;
  logic [WIDTH_W-1:0] ptr_inc;
  logic [LINE_AW-1:0] ptr_adv;
  logic [SUM_W-1:0]   sum_new;
  logic               cut_new, failed_new;
  logic [POS_W-1:0]   pos_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width <= WIDTH_RESET;
      cfg_thr   <= THR_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_WINDOW_WIDTH:      cfg_width <= cfg_data[WIDTH_W-1:0];
        CFG_QUALITY_THRESHOLD: cfg_thr   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    q_raw = (in_item.quality_char < PHRED_OFFSET) ? '0 : in_item.quality_char - PHRED_OFFSET;
    q     = (q_raw > CHAR_W'(QUAL_MAX)) ? QUAL_MAX : q_raw[QUAL_W-1:0];

    if (cfg_width == '0) begin
      width_sat = WIDTH_W'(1);
    end else if (cfg_width > WIDTH_LIMIT) begin
      width_sat = WIDTH_LIMIT;
    end else begin
      width_sat = cfg_width;
    end

    first   = (base_position == '0);
    active  = (base_position != POS_LIMIT);
    cur_w   = first ? width_sat : eff_width;
    cur_thr = first ? cfg_thr : eff_thr;
    limit   = LIMIT_W'(cur_thr) * LIMIT_W'(cur_w);

    filling = base_position < POS_W'(cur_w);
    sliding = !filling && !read_failed && !cut_found;
    pos_inc = base_position + POS_W'(1);

    ptr_inc = WIDTH_W'(line_ptr) + WIDTH_W'(1);
    ptr_adv = (ptr_inc >= cur_w) ? '0 : ptr_inc[LINE_AW-1:0];

    if (filling) begin
      sum_new = window_sum + SUM_W'(q);
    end else begin
      sum_new = window_sum - SUM_W'(line_rd_data) + SUM_W'(q);
    end
    fails = LIMIT_W'({sum_new, 4'b0000}) < limit;
    good  = {q, 4'b0000} >= cur_thr;

    cut_new    = cut_found || (active && sliding && fails);
    failed_new = read_failed || (active && filling && (pos_inc == POS_W'(cur_w)) && fails);
    pos_new    = active ? pos_inc : base_position;

    eff_width_next     = eff_width;
    eff_thr_next       = eff_thr;
    window_sum_next    = window_sum;
    base_position_next = base_position;
    cut_found_next     = cut_found;
    last_good_end_next = last_good_end;
    read_failed_next   = read_failed;
    line_ptr_next      = line_ptr;

    line_ctl.wr_en   = 1'b0;
    line_ctl.wr_addr = line_ptr;
    line_ctl.wr_data = q;

    res_valid            = 1'b0;
    res_data.keep_read   = 1'b0;
    res_data.keep_length = '0;

    if (in_fire) begin
      if (active) begin
        if (first) begin
          eff_width_next = width_sat;
          eff_thr_next   = cfg_thr;
        end
        if (filling || sliding) begin
          window_sum_next = sum_new;
          line_ctl.wr_en  = 1'b1;
          line_ptr_next   = ptr_adv;
        end
        if (!cut_new && good) begin
          last_good_end_next = pos_inc;
        end
        cut_found_next     = cut_new;
        read_failed_next   = failed_new;
        base_position_next = pos_new;
      end
      if (in_item.last_of_read) begin
        res_valid = 1'b1;
        if (!(pos_new < POS_W'(cur_w)) && !failed_new) begin
          res_data.keep_read   = 1'b1;
          res_data.keep_length = last_good_end_next;
        end
        window_sum_next    = '0;
        base_position_next = '0;
        cut_found_next     = 1'b0;
        last_good_end_next = POS_W'(1);
        read_failed_next   = 1'b0;
        line_ptr_next      = '0;
      end
    end

    line_ctl.rd_addr = line_ptr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width     <= WIDTH_RESET;
      eff_thr       <= THR_RESET;
      window_sum    <= '0;
      base_position <= '0;
      cut_found     <= 1'b0;
      last_good_end <= POS_W'(1);
      read_failed   <= 1'b0;
      line_ptr      <= '0;
    end else begin
      eff_width     <= eff_width_next;
      eff_thr       <= eff_thr_next;
      window_sum    <= window_sum_next;
      base_position <= base_position_next;
      cut_found     <= cut_found_next;
      last_good_end <= last_good_end_next;
      read_failed   <= read_failed_next;
      line_ptr      <= line_ptr_next;
    end
  end

endmodule

[rtl/sliding_window_quality_trim_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_quality_trim_top
// Streaming sliding-window Phred quality trimmer, one quality character a word.
// ----------------------------------------------------------------------------
//
// Channel | Handshake             | Word
// --------+-----------------------+------------------------------------------
// in      | in_valid / in_ready   | in_data: quality_char, last_of_read
// out     | out_valid / out_ready | out_data: keep_read, keep_length
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (width, threshold)
//
// The block accepts one quality character every cycle while the skid stage
// is empty, and folds each into the window sum in the cycle it is accepted; the
// result word of a read is registered on the cycle its last character is taken.
// The oldest window entry comes from a 64-entry delay line whose read port is
// prefetched, so the window update does not wait for the read.
// Reset is synchronous and active high; it restores the register defaults
// (width 4, threshold 320) and clears all per-read state.
// A result waits in the output register and a one-word skid stage; input
// stalls only while both hold a word.
// ----------------------------------------------------------------------------
module sliding_window_quality_trim_top
  import swqt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              in_fire;
  logic              res_valid;
  out_item_t         res_data;
  line_ctl_t         line_ctl;
  logic [QUAL_W-1:0] line_rd_data;

  // Registers are plain flops, so a configuration write is always taken.
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  swqt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_item      (in_data),
    .line_rd_data (line_rd_data),
    .line_ctl     (line_ctl),
    .res_valid    (res_valid),
    .res_data     (res_data)
  );

  swqt_window_line u_line (
    .clk     (clk),
    .ctl     (line_ctl),
    .rd_data (line_rd_data)
  );

  swqt_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res_data),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[tb/sliding_window_quality_trim_top_tb.sv]
// ----------------------------------------------------------------------------
// sliding_window_quality_trim_top_tb
// Self-checking bench for the sliding-window quality trimmer. A queue-fed
// driver streams quality words into the block, a cycle-level trim model
// predicts each read's keep flag and length, and a monitor compares every
// result word against the oldest prediction under random back-pressure.
// ----------------------------------------------------------------------------
module sliding_window_quality_trim_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swqt_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 5;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int PHASE_WORDS = 80;
  localparam int LONG_STALL  = 400;
  localparam int SETTLE      = 4;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_HALF) clk = ~clk;

  // Every block input starts at a known value.
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  cfg_index_t            cfg_index = CFG_WINDOW_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_ready;

  sliding_window_quality_trim_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Quality words waiting to be sent, and read results still owed by the block.
  in_item_t  quality_words [$];
  out_item_t trim_results [$];

  // Run-wide controls, each written by the main initial block only.
  int idle_pct      = 21;
  bit stall_request = 1'b0;

  // Counters, each owned by one process.
  int unsigned cycle_count   = 0;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned failures      = 0;
  int unsigned reads_built   = 0;
  int unsigned settings_used = 0;

  // Receiver hold-off state, owned by the monitor.
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  // --------------------------------------------------------------------------
  // Trim model. It mirrors the register file and the per-read state of the
  // block, and is stepped once per accepted quality word.
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0] reg_width  = WIDTH_RESET;
  logic [THR_W-1:0]   reg_thresh = THR_RESET;

  logic [QUAL_W-1:0] win_line [MAX_WINDOW];
  int unsigned win_sum    = 0;
  int unsigned base_pos   = 0;
  int unsigned cut_len    = 0;
  int unsigned good_end   = 1;
  int unsigned line_ptr   = 0;
  int unsigned lat_width  = 4;
  int unsigned lat_thresh = 320;
  bit          cut_seen   = 1'b0;
  bit          read_bad   = 1'b0;

  initial begin
    for (int i = 0; i < MAX_WINDOW; i++) win_line[i] = '0;
  end

  // A window fails when its mean is below the threshold; both sides are
  // scaled so the comparison stays in integers.
  function automatic bit window_below();
    return (win_sum * 16) < (lat_thresh * lat_width);
  endfunction

  task automatic trim_predict(input in_item_t word, output bit has_res,
                              output out_item_t res);
    int unsigned ch;
    int unsigned q;
    int unsigned p;
    int unsigned slot;
    ch = word.quality_char;
    // Characters below the Phred offset count as zero quality, and the delay
    // line only holds seven bits.
    q = (ch < PHRED_OFFSET) ? 0 : ch - PHRED_OFFSET;
    if (q > QUAL_MAX) q = QUAL_MAX;
    has_res = 1'b0;
    res = '0;
    // Bases past the maximum read length leave the state alone.
    if (base_pos < MAX_READ_LENGTH) begin
      p = base_pos;
      if (p == 0) begin
        // Width and threshold are latched at the first base of every read.
        if (reg_width == 0) begin
          lat_width = 1;
        end else if (reg_width > MAX_WINDOW) begin
          lat_width = MAX_WINDOW;
        end else begin
          lat_width = reg_width;
        end
        lat_thresh = reg_thresh;
        line_ptr = 0;
      end
      if (p < lat_width) begin
        // Filling the first window.
        win_sum += q;
        win_line[line_ptr % MAX_WINDOW] = QUAL_W'(q);
        line_ptr++;
        if (line_ptr >= lat_width) line_ptr = 0;
        if ((p + 1 == lat_width) && window_below()) read_bad = 1'b1;
      end else if (!read_bad && !cut_seen) begin
        // Slide: drop the oldest base, add the new one.
        slot = line_ptr % MAX_WINDOW;
        win_sum = win_sum - win_line[slot] + q;
        win_line[slot] = QUAL_W'(q);
        line_ptr++;
        if (line_ptr >= lat_width) line_ptr = 0;
        if (window_below()) begin
          cut_seen = 1'b1;
          cut_len = p;
        end
      end
      if (!cut_seen && (q * 16 >= lat_thresh)) good_end = p + 1;
      base_pos = p + 1;
    end
    if (word.last_of_read) begin
      has_res = 1'b1;
      if (!(base_pos < lat_width || read_bad)) begin
        res.keep_read = 1'b1;
        res.keep_length = POS_W'(good_end);
      end
      win_sum = 0;
      base_pos = 0;
      cut_seen = 1'b0;
      cut_len = 0;
      good_end = 1;
      read_bad = 1'b0;
      line_ptr = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Cycle counter, and the watchdog that ends a run which stops making
  // progress.
  // --------------------------------------------------------------------------
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, trim_results.size());
    $display("sliding_window_quality_trim_top verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input driver. At each rising edge it first notes a word accepted at that
  // edge and steps the trim model with it. It then either holds the current
  // word (valid up, not yet taken) or decides whether to present the next
  // queued word or idle. At most one assignment to in_valid per edge keeps
  // valid from dropping between back-to-back words.
  // --------------------------------------------------------------------------
  bit        drv_has_res;
  out_item_t drv_res;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        trim_predict(in_data, drv_has_res, drv_res);
        if (drv_has_res) trim_results.push_back(drv_res);
        words_sent <= words_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (quality_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= quality_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each accepted result word is checked field by field
  // against the oldest prediction. Output ready idles at random, except for
  // one long hold-off, counted here, which lets results pile up inside the
  // block until it stops taking input.
  // --------------------------------------------------------------------------
  out_item_t   mon_want;
  int unsigned mon_errs;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (trim_results.size() == 0) begin
        $error("Result word with no prediction waiting: keep_read %0d keep_length %0d",
               out_data.keep_read, out_data.keep_length);
        failures <= failures + 1;
      end else begin
        mon_want = trim_results.pop_front();
        mon_errs = 0;
        if (out_data.keep_read !== mon_want.keep_read) begin
          $error("keep_read mismatch: expected %0d, actual %0d",
                 mon_want.keep_read, out_data.keep_read);
          mon_errs++;
        end
        if (out_data.keep_length !== mon_want.keep_length) begin
          $error("keep_length mismatch: expected %0d, actual %0d",
                 mon_want.keep_length, out_data.keep_length);
          mon_errs++;
        end
        failures <= failures + mon_errs;
      end
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_request && !stall_done) begin
      out_ready  <= 1'b0;
      stall_left <= LONG_STALL;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_word(input int unsigned ch, input bit last);
    in_item_t word;
    word.quality_char = CHAR_W'(ch);
    word.last_of_read = last;
    quality_words.push_back(word);
    if (last) reads_built++;
  endtask

  // A register is written only while the block is idle; the model takes the
  // new value at the same edge as the block.
  task automatic write_reg(input cfg_index_t idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == CFG_WINDOW_WIDTH) begin
      reg_width = WIDTH_W'(val);
    end else begin
      reg_thresh = THR_W'(val);
    end
    cfg_valid <= 1'b0;
  endtask

  // The sender stops here until every queued word is in and every predicted
  // result has come out, and then lets the block settle.
  task automatic drain();
    while (quality_words.size() != 0 || in_valid || trim_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One random read. Most reads are a run of good bases followed by a tail
  // of weak ones, so the first window passes and the cut and trailing trim
  // get exercised; some reads are short of the window and some are noise.
  task automatic queue_read(input int unsigned width_reg, input int unsigned thr,
                            output int unsigned len);
    int unsigned w;
    int unsigned good_q;
    int unsigned tail;
    int unsigned q;
    int unsigned ch;
    bit          noisy;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WINDOW) ? MAX_WINDOW : width_reg);
    good_q = (thr + 15) / 16;
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(1, w);
    end else begin
      len = w + $urandom_range(0, 2 * w + 8);
    end
    noisy = ($urandom_range(0, 4) == 0);
    tail = $urandom_range(w, len + w);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        ch = $urandom_range(0, 255);
      end else begin
        if (i < tail) begin
          q = good_q + $urandom_range(0, 10);
          // An occasional dip that may or may not sink the window.
          if ($urandom_range(0, 15) == 0 && good_q != 0) q = $urandom_range(0, good_q - 1);
        end else if (good_q == 0 || $urandom_range(0, 2) == 0) begin
          q = good_q + $urandom_range(0, 3);
        end else begin
          q = $urandom_range(0, good_q - 1);
        end
        if (q > QUAL_MAX) q = QUAL_MAX;
        ch = (q == 0) ? $urandom_range(0, PHRED_OFFSET) : q + PHRED_OFFSET;
      end
      push_word(ch, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  int unsigned phase_width;
  int unsigned phase_thresh;
  int unsigned phase_count;
  int unsigned read_len;

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reads under the reset settings, width 4 and threshold 20.0.
    // A single zero character: shorter than the window.
    push_word(0, 1'b1);
    // Top-code characters clamp to the highest quality and keep all four.
    push_word(255, 1'b0);
    push_word(255, 1'b0);
    push_word(255, 1'b0);
    push_word(255, 1'b1);
    // Good start, then characters at and below the offset force a cut.
    push_word(73, 1'b0);
    push_word(73, 1'b0);
    push_word(73, 1'b0);
    push_word(73, 1'b0);
    push_word(33, 1'b0);
    push_word(0, 1'b0);
    push_word(73, 1'b0);
    push_word(20, 1'b1);
    // The first window is weak, so the read is dropped.
    push_word(40, 1'b0);
    push_word(40, 1'b0);
    push_word(40, 1'b0);
    push_word(40, 1'b1);
    // Weak bases at the end are trimmed without failing a window.
    push_word(73, 1'b0);
    push_word(73, 1'b0);
    push_word(73, 1'b0);
    push_word(73, 1'b0);
    push_word(73, 1'b0);
    push_word(53, 1'b0);
    push_word(52, 1'b0);
    push_word(40, 1'b1);
    drain();

    // Random phases. Each one programs both registers, then streams reads.
    // The first keeps the reset values and carries the long receiver
    // hold-off; the sixth runs with no idling on either side.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin phase_width = 4;   phase_thresh = 320;  end
        1: begin phase_width = 1;   phase_thresh = 0;    end
        2: begin phase_width = 0;   phase_thresh = 1504; end
        3: begin phase_width = 64;  phase_thresh = 1504; end
        4: begin phase_width = 127; phase_thresh = 2047; end
        5: begin phase_width = 2;   phase_thresh = 480;  end
        default: begin
          phase_width  = $urandom_range(1, 16);
          phase_thresh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 1504);
        end
      endcase
      write_reg(CFG_WINDOW_WIDTH, phase_width);
      write_reg(CFG_QUALITY_THRESHOLD, phase_thresh);
      settings_used++;
      idle_pct = (ph == 5) ? 0 : 21;
      if (ph == 0) stall_request = 1'b1;
      phase_count = 0;
      while (phase_count < PHASE_WORDS) begin
        queue_read(phase_width, phase_thresh, read_len);
        phase_count += read_len;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d quality words in %0d reads over %0d register settings.",
             words_sent, reads_built, settings_used);
    $display("Checked %0d result words, %0d mismatches.", results_seen, failures);
    if (failures == 0 && trim_results.size() == 0) begin
      $display("sliding_window_quality_trim_top verification clean");
    end else begin
      $display("sliding_window_quality_trim_top verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/swqt_pkg.sv
rtl/swqt_window_line.sv
rtl/swqt_out_buf.sv
rtl/swqt_core.sv
rtl/sliding_window_quality_trim_top.sv
tb/sliding_window_quality_trim_top_tb.sv
